// ===== hdl/malf_pkg.sv =====
// Shared types and constants for the MAC address list filter.
package malf_pkg;

	// Default number of table entries
	localparam int unsigned TABLE_DEPTH_DEF = 64;

	// Field widths
	localparam int unsigned MAC_W   = 48;
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned CNT_W   = 48;
	localparam int unsigned ECNT_W  = 7;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned CFGI_W  = 2;
	localparam int unsigned CFGD_W  = 7;

	// Configuration register indexes
	localparam logic [CFGI_W-1:0] REG_ENTRY_COUNT  = 2'd0;
	localparam logic [CFGI_W-1:0] REG_MATCH_MODE   = 2'd1;
	localparam logic [CFGI_W-1:0] REG_MATCH_ACTION = 2'd2;
	localparam logic [CFGI_W-1:0] REG_MISS_ACTION  = 2'd3;

	// Match modes
	localparam logic [MODE_W-1:0] MODE_SRC    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DST    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EITHER = 2'd2;

	// Command opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CHECK = 1'b1;

	// Verdict codes
	localparam logic ACT_PASS = 1'b0;
	localparam logic ACT_DROP = 1'b1;

	// One command transaction
	typedef struct packed {
		logic              op;
		logic [IDX_W-1:0]  entry_index;
		logic [MAC_W-1:0]  entry_mac;
		logic [MAC_W-1:0]  source_mac;
		logic [MAC_W-1:0]  dest_mac;
		logic [LEN_W-1:0]  packet_length;
	} cmd_t;

	// One result transaction
	typedef struct packed {
		logic              forward;
		logic              hit;
		logic [CNT_W-1:0]  dropped_total;
		logic [CNT_W-1:0]  passed_frames_total;
		logic [CNT_W-1:0]  passed_bytes_total;
	} rsp_t;

endpackage

// ===== hdl/mac_address_list_filter.sv =====
// MAC address list filter top level: config registers, scan sequencer, counters.
//
//  channel   signals                        handshake
//  -------   ----------------------------   ------------------------------------
//  command   start, busy, cmd (cmd_t)       taken when start && !busy
//  result    done, rsp (rsp_t)              valid one cycle while done is high
//  config    cfg_we, cfg_index, cfg_data    written when cfg_we is high
//
// A table write leaves busy low.
// A frame reads one table entry per cycle from the single RAM read port and stops
// at the first hit; a miss searches min(entry_count, TABLE_DEPTH) entries, and a
// frame with nothing to search goes from idle straight to the finish state. done
// rises at the edge where busy falls. Reset clears counters, config and state
// registers, not the frame payload or table. The result side cannot stall.
module mac_address_list_filter #(
	parameter int unsigned TABLE_DEPTH = malf_pkg::TABLE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  malf_pkg::cmd_t                cmd,
	output logic                          done,
	output malf_pkg::rsp_t                rsp,
	input  logic                          cfg_we,
	input  logic [malf_pkg::CFGI_W-1:0]   cfg_index,
	input  logic [malf_pkg::CFGD_W-1:0]   cfg_data
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned LW = (AW + 1 > malf_pkg::ECNT_W) ? AW + 1 : malf_pkg::ECNT_W;
	localparam logic [LW-1:0] DEPTH_L = LW'(TABLE_DEPTH);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

	state_t                          state_q;
	logic [malf_pkg::ECNT_W-1:0]     entry_count_q;
	logic [malf_pkg::MODE_W-1:0]     mode_q;
	logic                            match_act_q;
	logic                            miss_act_q;
	logic [LW-1:0]                   ptr_q;
	logic [LW-1:0]                   limit_q;
	logic                            vld_s1;
	logic                            hit_q;
	logic [malf_pkg::MAC_W-1:0]      src_q;
	logic [malf_pkg::MAC_W-1:0]      dst_q;
	logic [malf_pkg::LEN_W-1:0]      len_q;
	logic [malf_pkg::CNT_W-1:0]      drop_q;
	logic [malf_pkg::CNT_W-1:0]      pass_frm_q;
	logic [malf_pkg::CNT_W-1:0]      pass_byte_q;
	logic                            done_q;
	malf_pkg::rsp_t                  rsp_q;

	logic                            accept;
	logic [LW-1:0]                   idx_ext;
	logic [LW-1:0]                   cnt_ext;
	logic [LW-1:0]                   limit_d;
	logic                            wr_en;
	logic                            rd_en;
	logic [malf_pkg::MAC_W-1:0]      rd_data;
	logic                            entry_match;
	logic                            hit_now;
	logic                            verdict_drop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			mode_q        <= '0;
			match_act_q   <= 1'b0;
			miss_act_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				malf_pkg::REG_ENTRY_COUNT:  entry_count_q <= cfg_data;
				malf_pkg::REG_MATCH_MODE:   mode_q <= cfg_data[malf_pkg::MODE_W-1:0];
				malf_pkg::REG_MATCH_ACTION: match_act_q <= cfg_data[0];
				malf_pkg::REG_MISS_ACTION:  miss_act_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Command decode
	assign accept  = start && (state_q == S_IDLE);
	assign idx_ext = LW'(cmd.entry_index);
	assign cnt_ext = LW'(entry_count_q);
	assign limit_d = (cnt_ext > DEPTH_L) ? DEPTH_L : cnt_ext;
	assign wr_en   = accept && (cmd.op == malf_pkg::OP_WRITE) && (idx_ext < DEPTH_L);

	// Compare the entry read last cycle against the selected address(es)
	always_comb begin
		case (mode_q)
			malf_pkg::MODE_SRC:    entry_match = (rd_data == src_q);
			malf_pkg::MODE_DST:    entry_match = (rd_data == dst_q);
			malf_pkg::MODE_EITHER: entry_match = (rd_data == src_q) || (rd_data == dst_q);
			default:               entry_match = 1'b0;
		endcase
	end

	assign hit_now = (state_q == S_SCAN) && vld_s1 && entry_match;
	assign rd_en   = (state_q == S_SCAN) && (ptr_q < limit_q) && !hit_now;

	malf_table #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(idx_ext)),
		.wr_data (cmd.entry_mac),
		.rd_en   (rd_en),
		.rd_addr (AW'(ptr_q)),
		.rd_data (rd_data)
	);

	assign verdict_drop = hit_q ? match_act_q : miss_act_q;

	// Scan sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ptr_q       <= '0;
			limit_q     <= '0;
			vld_s1      <= 1'b0;
			hit_q       <= 1'b0;
			drop_q      <= '0;
			pass_frm_q  <= '0;
			pass_byte_q <= '0;
			done_q      <= 1'b0;
			rsp_q       <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					vld_s1 <= 1'b0;
					if (accept && (cmd.op == malf_pkg::OP_CHECK)) begin
						ptr_q   <= '0;
						limit_q <= limit_d;
						hit_q   <= 1'b0;
						// nothing to search: straight to the verdict
						if ((limit_d == '0) || (mode_q != malf_pkg::MODE_SRC &&
						    mode_q != malf_pkg::MODE_DST && mode_q != malf_pkg::MODE_EITHER)) begin
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					vld_s1 <= rd_en;
					if (rd_en) begin
						ptr_q <= ptr_q + 1'b1;
					end
					if (hit_now) begin
						hit_q   <= 1'b1;
						state_q <= S_FINISH;
					end else if (ptr_q == limit_q) begin
						// last entry compared this cycle without a hit
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					vld_s1        <= 1'b0;
					done_q        <= 1'b1;
					state_q       <= S_IDLE;
					rsp_q.forward <= (verdict_drop == malf_pkg::ACT_PASS);
					rsp_q.hit     <= hit_q;
					if (verdict_drop == malf_pkg::ACT_DROP) begin
						drop_q                    <= drop_q + 1'b1;
						rsp_q.dropped_total       <= drop_q + 1'b1;
						rsp_q.passed_frames_total <= pass_frm_q;
						rsp_q.passed_bytes_total  <= pass_byte_q;
					end else begin
						pass_frm_q                <= pass_frm_q + 1'b1;
						pass_byte_q               <= pass_byte_q + malf_pkg::CNT_W'(len_q);
						rsp_q.dropped_total       <= drop_q;
						rsp_q.passed_frames_total <= pass_frm_q + 1'b1;
						rsp_q.passed_bytes_total  <= pass_byte_q + malf_pkg::CNT_W'(len_q);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Frame payload
	always_ff @(posedge clk) begin
		if (accept && (cmd.op == malf_pkg::OP_CHECK)) begin
			src_q <= cmd.source_mac;
			dst_q <= cmd.dest_mac;
			len_q <= cmd.packet_length;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// Each frame gives a single-cycle strobe
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// Table reads stay inside the active entries
	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (ptr_q < limit_q) && (limit_q <= DEPTH_L))
		else $error("table read beyond active entries");

	// Reported totals match the live counters
	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.dropped_total == drop_q) && (rsp.passed_frames_total == pass_frm_q)
			&& (rsp.passed_bytes_total == pass_byte_q))
		else $error("result totals differ from counters");

	// No table write while a scan is running
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !wr_en)
		else $error("table written during a scan");

endmodule

// ===== hdl/malf_table.sv =====
// Address table RAM: one write port, one read port, registered read data.
module malf_table #(
	parameter int unsigned DEPTH = malf_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned AW    = 6
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [malf_pkg::MAC_W-1:0]  wr_data,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [malf_pkg::MAC_W-1:0]  rd_data
);

	logic [malf_pkg::MAC_W-1:0] mem [DEPTH];
	logic [malf_pkg::MAC_W-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, registered read data updated when rd_en is high
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
